### rtl/caus_pkg.sv
`default_nettype none

package caus_pkg;

   // Default sizes of the uplink table and the destination leaf table.
   localparam int NUM_UPLINKS_DEFAULT     = 8;
   localparam int NUM_DEST_LEAVES_DEFAULT = 64;

   // Metrics are unsigned Q8.24.
   localparam int METRIC_W  = 32;
   localparam int INT_BITS  = 8;
   localparam int FRAC_BITS = 24;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 20;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Divider widths: 8000 * bytes fits 45 bits, interval * rate fits 51 bits.
   localparam int DIV_NUM_W = 45;
   localparam int DIV_DEN_W = 51;

   // Products of a Q1.16 weight of at most one or a Q8.8 weight and a 32-bit metric fit 48 bits.
   localparam int WPROD_W = 48;

   localparam logic [16:0]        ONE_Q16    = 17'd65536;
   localparam logic [MUL_B_W-1:0] UTIL_SCALE = 20'd8000;
   localparam logic [MUL_B_W-1:0] RATE_SCALE = 20'd1000000;

   // Request operation codes.
   localparam logic [1:0] OP_SAMPLE   = 2'd0;
   localparam logic [1:0] OP_FEEDBACK = 2'd1;
   localparam logic [1:0] OP_QUERY    = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 19;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_RATE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_UTIL    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_QDELAY  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_LOCAL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_REMOTE = 3'd4;

   localparam logic [18:0] LINK_RATE_RESET = 19'd10000;
   localparam logic [16:0] ALPHA_RESET     = 17'd6554;
   localparam logic [15:0] WEIGHT_RESET    = 16'd256;

   typedef struct packed {
      logic [1:0]  operation;
      logic [2:0]  uplink;
      logic [5:0]  dest_leaf;
      logic [31:0] dequeued_bytes;
      logic [31:0] interval_ns;
      logic [31:0] queue_bytes;
      logic [31:0] remote_metric;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  chosen_uplink;
      logic [31:0] best_local_metric;
      logic [31:0] best_combined_metric;
   } rsp_payload_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_op_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [METRIC_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

### rtl/caus_mul.sv
`default_nettype none

module caus_mul (
   input  wire logic                         clock,
   input  wire caus_pkg::mul_op_type         mul_op,
   output logic [caus_pkg::MUL_P_W-1:0]      mul_product
);

   localparam int P_W = caus_pkg::MUL_P_W;

   logic [P_W-1:0] product_ff;

   // The product of the operands presented in one cycle appears in the next.
   always_ff @(posedge clock) begin
      product_ff <= P_W'(mul_op.a) * P_W'(mul_op.b);
   end

   assign mul_product = product_ff;

endmodule

`default_nettype wire

### rtl/caus_div.sv
`default_nettype none

module caus_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire caus_pkg::div_req_type div_req,
   output caus_pkg::div_rsp_type      div_rsp
);

   localparam int NW    = caus_pkg::DIV_NUM_W;
   localparam int DW    = caus_pkg::DIV_DEN_W;
   localparam int QW    = caus_pkg::METRIC_W;
   localparam int IB    = caus_pkg::INT_BITS;
   localparam int FB    = caus_pkg::FRAC_BITS;
   localparam int CNT_W = $clog2(QW);

   logic             busy_ff, busy_in;
   logic             check_ff, check_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    low_ff, low_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [QW-1:0]    quo_ff, quo_in;

   logic [DW:0]      trial;
   logic [DW:0]      diff;
   logic             fits;

   // Restoring division of num * 2^24 by den, one quotient bit per cycle.
   // The partial remainder starts at num / 256; if that already reaches den,
   // the quotient would not fit 32 bits and saturates.
   assign trial = {rem_ff, low_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = ~diff[DW];

   // The done flag stays high from the end of a division until the next start,
   // so a caller that looks late still sees the finished quotient.
   always_comb begin
      busy_in  = busy_ff;
      check_in = check_ff;
      done_in  = done_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         check_in = 1'b1;
         done_in  = 1'b0;
         cnt_in   = '0;
         rem_in   = DW'(div_req.num[NW-1:IB]);
         low_in   = {div_req.num[IB-1:0], {FB{1'b0}}};
         den_in   = div_req.den;
      end else if (busy_ff && check_ff) begin
         if (rem_ff >= den_ff) begin
            quo_in  = '1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            check_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff[DW-1:0];
         end else begin
            rem_in = trial[DW-1:0];
         end
         low_in = {low_ff[QW-2:0], 1'b0};
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         check_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         check_ff <= check_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/congestion_aware_uplink_select_unit.sv
`default_nettype none

// Leaf uplink selector. Requests are taken one at a time on req_valid/req_ready;
// a route query answers with one item on rsp, samples and feedback answer with
// nothing. A feedback request is absorbed in the cycle it is accepted. A rate
// sample makes two passes through the single radix-2 divider (utilization,
// then queue delay), with the moving average updates done on the shared 32x20
// multiplier; a sample with an out-of-range uplink or a zero interval or link
// rate is dropped. In a route query the sequencer walks the uplink table one
// entry at a time (table read, multiply, add and compare). After reset the
// block clears its tables and holds req_ready low meanwhile; csr writes are
// taken at any time. A finished query result waits in the output register
// while the next request is taken.
module congestion_aware_uplink_select_unit #(
   parameter int NUM_UPLINKS     = caus_pkg::NUM_UPLINKS_DEFAULT,
   parameter int NUM_DEST_LEAVES = caus_pkg::NUM_DEST_LEAVES_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire caus_pkg::req_payload_type          req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output caus_pkg::rsp_payload_type               rsp_payload,
   input  wire logic                               csr_write_enable,
   input  wire logic [caus_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [caus_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int UP_AW     = (NUM_UPLINKS > 1) ? $clog2(NUM_UPLINKS) : 1;
   localparam int LEAF_AW   = (NUM_DEST_LEAVES > 1) ? $clog2(NUM_DEST_LEAVES) : 1;
   localparam int CLR_DEPTH = (NUM_UPLINKS > NUM_DEST_LEAVES) ? NUM_UPLINKS
                                                              : NUM_DEST_LEAVES;
   localparam int CLR_AW    = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
   localparam int MW        = caus_pkg::METRIC_W;
   localparam int WP        = caus_pkg::WPROD_W;
   localparam int NW        = caus_pkg::DIV_NUM_W;
   localparam int DW        = caus_pkg::DIV_DEN_W;
   localparam int BW        = caus_pkg::MUL_B_W;
   localparam int DQ_W      = 39;

   typedef enum logic [19:0] {
      ST_CLEAR     = 20'h00001,
      ST_IDLE      = 20'h00002,
      ST_SMP_CHECK = 20'h00004,
      ST_SMP_MQ    = 20'h00008,
      ST_SMP_MU    = 20'h00010,
      ST_SMP_DU    = 20'h00020,
      ST_SMP_WU    = 20'h00040,
      ST_SMP_BU1   = 20'h00080,
      ST_SMP_BU2   = 20'h00100,
      ST_SMP_BU3   = 20'h00200,
      ST_SMP_WQ    = 20'h00400,
      ST_SMP_BQ1   = 20'h00800,
      ST_SMP_BQ2   = 20'h01000,
      ST_SMP_BQ3   = 20'h02000,
      ST_QRY_RD    = 20'h04000,
      ST_QRY_WR    = 20'h08000,
      ST_QRY_SUM   = 20'h10000,
      ST_QRY_MUL   = 20'h20000,
      ST_QRY_CMP   = 20'h40000,
      ST_QRY_DONE  = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   caus_pkg::req_payload_type req_ff, req_in;
   caus_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [18:0] link_rate_ff, link_rate_in;
   logic [16:0] alpha_util_ff, alpha_util_in;
   logic [16:0] alpha_qdelay_ff, alpha_qdelay_in;
   logic [15:0] weight_local_ff, weight_local_in;
   logic [15:0] weight_remote_ff, weight_remote_in;

   logic [CLR_AW-1:0] clr_ff, clr_in;
   logic [UP_AW-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]     den_u_ff, den_u_in;
   logic [DQ_W-1:0]   den_q_ff, den_q_in;
   logic [MW-1:0]     u_ff, u_in;
   logic [WP-1:0]     p1_ff, p1_in;
   logic [MW-1:0]     newu_ff, newu_in;
   logic [WP-1:0]     wrr_ff, wrr_in;
   logic [MW-1:0]     loc_ff, loc_in;
   logic [UP_AW-1:0]  best_c_ff, best_c_in;
   logic [MW-1:0]     best_m_ff, best_m_in;
   logic [MW-1:0]     best_l_ff, best_l_in;

   // Uplink table: utilization average in the upper half, queue delay below.
   logic [2*MW-1:0] local_mem [NUM_UPLINKS];
   logic [MW-1:0]   remote_mem [NUM_DEST_LEAVES];
   logic [2*MW-1:0] local_rd_ff;
   logic [MW-1:0]   remote_rd_ff;

   logic               loc_we;
   logic [UP_AW-1:0]   loc_waddr, loc_raddr;
   logic [2*MW-1:0]    loc_wdata;
   logic               rem_we;
   logic [LEAF_AW-1:0] rem_waddr, rem_raddr;
   logic [MW-1:0]      rem_wdata;

   caus_pkg::mul_op_type            mul_op;
   logic [caus_pkg::MUL_P_W-1:0]    mul_product;
   caus_pkg::div_req_type           div_req;
   caus_pkg::div_rsp_type           div_rsp;

   logic               req_accept;
   logic               query_state;
   logic               clr_last;
   logic               cnt_last;
   logic [7:0]         up_ext;
   logic [UP_AW-1:0]   up_addr;
   logic               up_ok;
   logic [15:0]        leaf_ext, leaf_ext_req;
   logic [LEAF_AW-1:0] leaf_addr, leaf_addr_req;
   logic               leaf_ok, leaf_ok_req;
   logic [16:0]        wu, wq;
   logic [MW-1:0]      remote_val;
   logic [MW:0]        loc_sum;
   logic [WP-1:0]      blend_sum;
   logic [WP:0]        comb_sum;
   logic [WP-8:0]      comb_shift;
   logic [MW-1:0]      comb_metric;
   logic [7:0]         best_c_ext;

   caus_mul u_mul (
      .clock       (clock),
      .mul_op      (mul_op),
      .mul_product (mul_product)
   );

   caus_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Addresses derived from the held request and from the incoming one.
   assign up_ext        = {5'b0, req_ff.uplink};
   assign up_addr       = up_ext[UP_AW-1:0];
   assign up_ok         = up_ext < 8'(NUM_UPLINKS);
   assign leaf_ext      = {10'b0, req_ff.dest_leaf};
   assign leaf_addr     = leaf_ext[LEAF_AW-1:0];
   assign leaf_ok       = leaf_ext < 16'(NUM_DEST_LEAVES);
   assign leaf_ext_req  = {10'b0, req_payload.dest_leaf};
   assign leaf_addr_req = leaf_ext_req[LEAF_AW-1:0];
   assign leaf_ok_req   = leaf_ext_req < 16'(NUM_DEST_LEAVES);

   // Averaging weights above one act as one.
   assign wu = (alpha_util_ff > caus_pkg::ONE_Q16) ? caus_pkg::ONE_Q16 : alpha_util_ff;
   assign wq = (alpha_qdelay_ff > caus_pkg::ONE_Q16) ? caus_pkg::ONE_Q16 : alpha_qdelay_ff;

   assign remote_val  = leaf_ok ? remote_rd_ff : '0;
   assign loc_sum     = {1'b0, local_rd_ff[2*MW-1:MW]} + {1'b0, local_rd_ff[MW-1:0]};
   assign blend_sum   = p1_ff + mul_product[WP-1:0];
   assign comb_sum    = {1'b0, mul_product[WP-1:0]} + {1'b0, wrr_ff};
   assign comb_shift  = comb_sum[WP:8];
   assign comb_metric = (|comb_shift[WP-8:MW]) ? '1 : comb_shift[MW-1:0];
   assign best_c_ext  = 8'(best_c_ff);

   assign clr_last = (clr_ff == CLR_AW'(CLR_DEPTH - 1));
   assign cnt_last = (cnt_ff == UP_AW'(NUM_UPLINKS - 1));
   assign query_state = (state_ff == ST_QRY_RD) || (state_ff == ST_QRY_WR) ||
                        (state_ff == ST_QRY_SUM) || (state_ff == ST_QRY_MUL) ||
                        (state_ff == ST_QRY_CMP);

   always_comb begin
      link_rate_in     = link_rate_ff;
      alpha_util_in    = alpha_util_ff;
      alpha_qdelay_in  = alpha_qdelay_ff;
      weight_local_in  = weight_local_ff;
      weight_remote_in = weight_remote_ff;
      if (csr_write_enable) begin
         case (csr_index)
            caus_pkg::CSR_LINK_RATE:     link_rate_in     = csr_write_data;
            caus_pkg::CSR_ALPHA_UTIL:    alpha_util_in    = csr_write_data[16:0];
            caus_pkg::CSR_ALPHA_QDELAY:  alpha_qdelay_in  = csr_write_data[16:0];
            caus_pkg::CSR_WEIGHT_LOCAL:  weight_local_in  = csr_write_data[15:0];
            caus_pkg::CSR_WEIGHT_REMOTE: weight_remote_in = csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      clr_in         = clr_ff;
      cnt_in         = cnt_ff;
      den_u_in       = den_u_ff;
      den_q_in       = den_q_ff;
      u_in           = u_ff;
      p1_in          = p1_ff;
      newu_in        = newu_ff;
      wrr_in         = wrr_ff;
      loc_in         = loc_ff;
      best_c_in      = best_c_ff;
      best_m_in      = best_m_ff;
      best_l_in      = best_l_ff;
      mul_op         = '0;
      div_req        = '0;
      loc_we         = 1'b0;
      loc_waddr      = up_addr;
      loc_wdata      = {newu_ff, blend_sum[WP-1:16]};
      loc_raddr      = up_addr;
      rem_we         = 1'b0;
      rem_waddr      = leaf_addr_req;
      rem_wdata      = req_payload.remote_metric;
      rem_raddr      = leaf_addr;

      case (state_ff)
         ST_CLEAR: begin
            loc_we    = ({1'b0, clr_ff} < (CLR_AW + 1)'(NUM_UPLINKS));
            loc_waddr = clr_ff[UP_AW-1:0];
            loc_wdata = '0;
            rem_we    = ({1'b0, clr_ff} < (CLR_AW + 1)'(NUM_DEST_LEAVES));
            rem_waddr = clr_ff[LEAF_AW-1:0];
            rem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               req_in = req_payload;
               cnt_in = '0;
               case (req_payload.operation)
                  caus_pkg::OP_SAMPLE:   state_in = ST_SMP_CHECK;
                  caus_pkg::OP_FEEDBACK: rem_we   = leaf_ok_req;
                  caus_pkg::OP_QUERY:    state_in = ST_QRY_RD;
                  default: ;
               endcase
            end
         end
         ST_SMP_CHECK: begin
            if (!up_ok || (req_ff.interval_ns == '0) || (link_rate_ff == '0)) begin
               state_in = ST_IDLE;
            end else begin
               mul_op.a = req_ff.interval_ns;
               mul_op.b = BW'(link_rate_ff);
               state_in = ST_SMP_MQ;
            end
         end
         ST_SMP_MQ: begin
            den_u_in = mul_product[DW-1:0];
            mul_op.a = 32'(link_rate_ff);
            mul_op.b = caus_pkg::RATE_SCALE;
            state_in = ST_SMP_MU;
         end
         ST_SMP_MU: begin
            den_q_in = mul_product[DQ_W-1:0];
            mul_op.a = req_ff.dequeued_bytes;
            mul_op.b = caus_pkg::UTIL_SCALE;
            state_in = ST_SMP_DU;
         end
         ST_SMP_DU: begin
            div_req.start = 1'b1;
            div_req.num   = mul_product[NW-1:0];
            div_req.den   = den_u_ff;
            state_in      = ST_SMP_WU;
         end
         ST_SMP_WU: begin
            if (div_rsp.done) begin
               u_in          = div_rsp.quotient;
               div_req.start = 1'b1;
               div_req.num   = NW'({req_ff.queue_bytes, 3'b000});
               div_req.den   = DW'(den_q_ff);
               state_in      = ST_SMP_BU1;
            end
         end
         // The utilization average is folded while the queue delay divides.
         ST_SMP_BU1: begin
            mul_op.a = local_rd_ff[2*MW-1:MW];
            mul_op.b = BW'(caus_pkg::ONE_Q16 - wu);
            state_in = ST_SMP_BU2;
         end
         ST_SMP_BU2: begin
            p1_in    = mul_product[WP-1:0];
            mul_op.a = u_ff;
            mul_op.b = BW'(wu);
            state_in = ST_SMP_BU3;
         end
         ST_SMP_BU3: begin
            newu_in  = blend_sum[WP-1:16];
            state_in = ST_SMP_WQ;
         end
         ST_SMP_WQ: begin
            if (div_rsp.done) begin
               state_in = ST_SMP_BQ1;
            end
         end
         ST_SMP_BQ1: begin
            mul_op.a = local_rd_ff[MW-1:0];
            mul_op.b = BW'(caus_pkg::ONE_Q16 - wq);
            state_in = ST_SMP_BQ2;
         end
         ST_SMP_BQ2: begin
            p1_in    = mul_product[WP-1:0];
            mul_op.a = div_rsp.quotient;
            mul_op.b = BW'(wq);
            state_in = ST_SMP_BQ3;
         end
         ST_SMP_BQ3: begin
            loc_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_QRY_RD: begin
            state_in = ST_QRY_WR;
         end
         ST_QRY_WR: begin
            mul_op.a = remote_val;
            mul_op.b = BW'(weight_remote_ff);
            state_in = ST_QRY_SUM;
         end
         ST_QRY_SUM: begin
            // The weighted remote term is the same for every uplink.
            if (cnt_ff == '0) begin
               wrr_in = mul_product[WP-1:0];
            end
            loc_in   = loc_sum[MW] ? '1 : loc_sum[MW-1:0];
            state_in = ST_QRY_MUL;
         end
         ST_QRY_MUL: begin
            mul_op.a = loc_ff;
            mul_op.b = BW'(weight_local_ff);
            state_in = ST_QRY_CMP;
         end
         ST_QRY_CMP: begin
            if ((cnt_ff == '0) || (comb_metric < best_m_ff)) begin
               best_m_in = comb_metric;
               best_c_in = cnt_ff;
            end
            if ((cnt_ff == '0) || (loc_ff < best_l_ff)) begin
               best_l_in = loc_ff;
            end
            if (cnt_last) begin
               state_in = ST_QRY_DONE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_QRY_SUM;
            end
         end
         ST_QRY_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                        = 1'b1;
               rsp_payload_in.chosen_uplink        = best_c_ext[2:0];
               rsp_payload_in.best_local_metric    = best_l_ff;
               rsp_payload_in.best_combined_metric = best_m_ff;
               state_in                            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // During a query the table is read one entry ahead of the walk.
      if (query_state) begin
         loc_raddr = cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (loc_we) begin
         local_mem[loc_waddr] <= loc_wdata;
      end
      local_rd_ff <= local_mem[loc_raddr];
   end

   always_ff @(posedge clock) begin
      if (rem_we) begin
         remote_mem[rem_waddr] <= rem_wdata;
      end
      remote_rd_ff <= remote_mem[rem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         rsp_valid_ff     <= 1'b0;
         clr_ff           <= '0;
         cnt_ff           <= '0;
         link_rate_ff     <= caus_pkg::LINK_RATE_RESET;
         alpha_util_ff    <= caus_pkg::ALPHA_RESET;
         alpha_qdelay_ff  <= caus_pkg::ALPHA_RESET;
         weight_local_ff  <= caus_pkg::WEIGHT_RESET;
         weight_remote_ff <= caus_pkg::WEIGHT_RESET;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         clr_ff           <= clr_in;
         cnt_ff           <= cnt_in;
         link_rate_ff     <= link_rate_in;
         alpha_util_ff    <= alpha_util_in;
         alpha_qdelay_ff  <= alpha_qdelay_in;
         weight_local_ff  <= weight_local_in;
         weight_remote_ff <= weight_remote_in;
      end
      req_ff         <= req_in;
      rsp_payload_ff <= rsp_payload_in;
      den_u_ff       <= den_u_in;
      den_q_ff       <= den_q_in;
      u_ff           <= u_in;
      p1_ff          <= p1_in;
      newu_ff        <= newu_in;
      wrr_ff         <= wrr_in;
      loc_ff         <= loc_in;
      best_c_ff      <= best_c_in;
      best_m_ff      <= best_m_in;
      best_l_ff      <= best_l_in;
   end

   // The queue delay quotient is ready by the time the sequencer folds it.
   a_qdelay_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SMP_BQ1) |-> div_rsp.done)
      else $error("queue delay folded before the divider finished");

   // A new result comes only from the end of a query walk.
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_QRY_DONE))
      else $error("result raised without a finished query");

   // The walk never steps past the last uplink.
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      query_state |-> ({1'b0, cnt_ff} < (UP_AW + 1)'(NUM_UPLINKS)))
      else $error("uplink walk index out of range");

endmodule

`default_nettype wire
